### rtl/bulk_ticket_shift_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bulk ticket shift queue
// Shared concurrent assertion forms. Each expects a signal named clock, and
// BSTQ_ASSERT also one named reset, in the scope where the macro is used.
// ----------------------------------------------------------------------------
`ifndef BULK_TICKET_SHIFT_QUEUE_DEFINES_SVH
`define BULK_TICKET_SHIFT_QUEUE_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define BSTQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define BSTQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/bstq_pkg.sv
// ----------------------------------------------------------------------------
// Bulk ticket shift queue package
// Field widths, opcode and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bstq_pkg;

   // Field widths of one request and one response beat.
   localparam int OPCODE_W = 2;
   localparam int COUNT_W  = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int TICKET_W = 32;

   // Packed bus widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   // Bit positions inside the packed buses.
   localparam int REQ_COUNT_LSB  = OPCODE_W;
   localparam int RSP_OCC_LSB    = STATUS_W;
   localparam int RSP_TICKET_LSB = STATUS_W + OCC_W;
   localparam int RSP_USED_W     = STATUS_W + OCC_W + TICKET_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQ    = 2'd0,
      OP_DEQ    = 2'd1,
      OP_REPORT = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch opcode and count, clear step counters
      logic enq_commit;  // append tickets, advance counter and fill level
      logic deq_commit;  // drop count entries from the fill level
      logic shift;       // one binary stage of the head shift
      logic rotate;      // rotate live entries by one toward the head
      logic emit;        // load the response register
      logic emit_entry;  // response carries the head entry
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      opcode_type op;
      logic       under;       // dequeue count exceeds the fill level
      logic       fill_zero;   // queue is empty
      logic       shift_last;  // final shift stage is active
      logic       walk_last;   // report is at the tail entry
   } dp_stat_type;

endpackage

`default_nettype wire

### rtl/bulk_ticket_shift_queue.sv
// ----------------------------------------------------------------------------
// Bulk ticket shift queue
// Shifting queue of ticket numbers with batch enqueue, batch dequeue and a
// report that streams every entry from the head.
//
//   Channel  Direction  Beat contents
//   req_     in         tdata: opcode, count
//   rsp_     out        tdata: status, occupancy, ticket; tuser: entry_valid;
//                       tlast: last
//
// One request is in flight at a time; the request side is ready only while
// the controller is idle, and the response register lets the next request
// enter while the last beat still waits.
// Enqueue, failed dequeue, empty report and the unused opcode answer from the
// execute state. A dequeue first runs the binary stages of the head shift; a
// report emits one beat and one rotation per entry.
// A stalled response holds the walk and the queue state.
// Reset is synchronous and clears the fill level and the ticket counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bulk_ticket_shift_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request: [1:0] opcode, [9:2] count, [15:10] zero
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [bstq_pkg::REQ_DATA_W-1:0] req_tdata,
   // Response: [1:0] status, [6:2] occupancy, [38:7] ticket, [39] zero
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [bstq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   // Response user: [0] entry_valid
   output logic                                 rsp_tuser
);
   import bstq_pkg::*;

   dp_cmd_type           cmd;
   dp_stat_type          stat;
   logic [STATUS_W-1:0]  rsp_status;
   logic [OCC_W-1:0]     rsp_occupancy;
   logic [TICKET_W-1:0]  rsp_ticket;

   // Controller.
   bstq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath.
   bstq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_tdata[OPCODE_W-1:0]),
      .req_count       (req_tdata[REQ_COUNT_LSB +: COUNT_W]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_ticket      (rsp_ticket),
      .rsp_entry_valid (rsp_tuser),
      .rsp_last        (rsp_tlast)
   );

   // Pack the response beat, lowest field first.
   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, rsp_ticket, rsp_occupancy, rsp_status};

endmodule

`default_nettype wire

### rtl/bstq_ctrl.sv
// ----------------------------------------------------------------------------
// Bulk ticket shift queue controller
// Sequences one request at a time through execute, shift, finish and walk
// states, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bstq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire bstq_pkg::dp_stat_type stat,
   output bstq_pkg::dp_cmd_type      cmd
);
   import bstq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_DONE  = 5'b01000,
      S_WALK  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register can take a new beat when empty or being drained.
   // The request side stays closed while reset is held.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.op == OP_DEQ && !stat.under) begin
               state_in = S_SHIFT;
            end else if (stat.op == OP_REPORT && !stat.fill_zero) begin
               state_in = S_WALK;
            end else if (out_free) begin
               cmd.emit       = 1'b1;
               cmd.enq_commit = (stat.op == OP_ENQ);
               state_in       = S_IDLE;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.deq_commit = 1'b1;
               cmd.emit       = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_WALK: begin
            if (out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_entry = 1'b1;
               cmd.rotate     = 1'b1;
               if (stat.walk_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The valid flag rises on a new beat and falls when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/bstq_dp.sv
// ----------------------------------------------------------------------------
// Bulk ticket shift queue datapath
// Register file of tickets with parallel append, a binary staged head shift,
// a one-place rotation for reports, and the response payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module bstq_dp #(
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bstq_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic [bstq_pkg::COUNT_W-1:0]  req_count,
   input  wire bstq_pkg::dp_cmd_type          cmd,
   output bstq_pkg::dp_stat_type              stat,
   output logic [bstq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bstq_pkg::OCC_W-1:0]         rsp_occupancy,
   output logic [bstq_pkg::TICKET_W-1:0]      rsp_ticket,
   output logic                               rsp_entry_valid,
   output logic                               rsp_last
);
   import bstq_pkg::*;

   localparam int FW = $clog2(DEPTH + 1);  // fill level, holds DEPTH
   localparam int IW = $clog2(DEPTH);      // entry index
   localparam int SW = $clog2(FW);         // shift stage index

   logic [TICKET_W-1:0] entries_ff [DEPTH];
   logic [TICKET_W-1:0] entries_in [DEPTH];
   logic [TICKET_W-1:0] shift_src  [DEPTH][FW];
   logic [TICKET_W-1:0] rot_src    [DEPTH];

   logic [FW-1:0]       fill_ff, fill_in;
   logic [TICKET_W-1:0] ticket_ff, ticket_in;
   logic [SW-1:0]       stage_ff, stage_in;
   logic [IW-1:0]       idx_ff, idx_in;
   opcode_type          op_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic [FW-1:0]       space;
   logic [FW-1:0]       take;
   logic                overflow;
   logic                under;
   logic [FW-1:0]       fill_enq;
   logic [FW-1:0]       fill_deq;
   logic [TICKET_W-1:0] base;
   logic [IW-1:0]       walk_end;
   status_type          status_sel;

   // Enqueue sizing: how many tickets fit and where the run starts.
   assign space    = FW'(DEPTH) - fill_ff;
   assign overflow = count_ff > COUNT_W'(space);
   assign take     = overflow ? space : FW'(count_ff);
   assign fill_enq = fill_ff + take;
   assign base     = ticket_ff + TICKET_W'(1) - TICKET_W'(fill_ff);

   // Dequeue check and the fill level left after it.
   assign under    = count_ff > COUNT_W'(fill_ff);
   assign fill_deq = fill_ff - FW'(count_ff);

   // Tail position of the live entries during a report walk.
   assign walk_end = IW'(fill_ff - FW'(1));

   // Status to the controller.
   assign stat.op         = op_ff;
   assign stat.under      = under;
   assign stat.fill_zero  = (fill_ff == '0);
   assign stat.shift_last = (stage_ff == SW'(FW - 1));
   assign stat.walk_last  = (idx_ff == walk_end);

   // Per-entry next value: append, shift stage or rotation.
   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      for (genvar k = 0; k < FW; k++) begin : g_stage
         if (i + (2 ** k) < DEPTH) begin : g_in
            assign shift_src[i][k] = entries_ff[i + (2 ** k)];
         end else begin : g_out
            assign shift_src[i][k] = '0;
         end
      end

      if (i + 1 < DEPTH) begin : g_rot
         assign rot_src[i] = entries_ff[i + 1];
      end else begin : g_wrap
         assign rot_src[i] = entries_ff[0];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (cmd.enq_commit) begin
            if (FW'(i) >= fill_ff && COUNT_W'(FW'(i) - fill_ff) < count_ff) begin
               entries_in[i] = base + TICKET_W'(i);
            end
         end else if (cmd.shift) begin
            for (int k = 0; k < FW; k++) begin
               if (stage_ff == SW'(k) && count_ff[k]) begin
                  entries_in[i] = shift_src[i][k];
               end
            end
         end else if (cmd.rotate) begin
            entries_in[i] = (IW'(i) == walk_end) ? entries_ff[0] : rot_src[i];
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   // Fill level, ticket counter and step counters.
   always_comb begin
      fill_in   = fill_ff;
      ticket_in = ticket_ff;
      stage_in  = stage_ff;
      idx_in    = idx_ff;
      if (cmd.enq_commit) begin
         fill_in   = fill_enq;
         ticket_in = ticket_ff + TICKET_W'(count_ff);
      end
      if (cmd.deq_commit) begin
         fill_in = fill_deq;
      end
      if (cmd.capture) begin
         stage_in = '0;
         idx_in   = '0;
      end
      if (cmd.shift) begin
         stage_in = stage_ff + SW'(1);
      end
      if (cmd.rotate) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         ticket_ff <= '0;
         stage_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         fill_ff   <= fill_in;
         ticket_ff <= ticket_in;
         stage_ff  <= stage_in;
         idx_ff    <= idx_in;
      end
   end

   // Request fields held for the duration of the operation.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= opcode_type'(req_opcode);
         count_ff <= req_count;
      end
   end

   // Status reported for the current operation.
   always_comb begin
      status_sel = ST_OK;
      if (op_ff == OP_ENQ && overflow) begin
         status_sel = ST_OVER;
      end else if (op_ff == OP_DEQ && under) begin
         status_sel = ST_UNDER;
      end
   end

   // Response payload register; occupancy shows the level after the update.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status    <= status_sel;
         rsp_occupancy <= OCC_W'(fill_in);
         if (cmd.emit_entry) begin
            rsp_ticket      <= entries_ff[0];
            rsp_entry_valid <= 1'b1;
            rsp_last        <= (idx_ff == walk_end);
         end else begin
            rsp_ticket      <= '0;
            rsp_entry_valid <= 1'b0;
            rsp_last        <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/bstq_checker.sv
// ----------------------------------------------------------------------------
// Bulk ticket shift queue port checker
// Watches the top-level ports for response and request ordering rules and
// is bound to every instance of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bulk_ticket_shift_queue_defines.svh"

module bstq_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [bstq_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [bstq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic                            rsp_tuser
);
   import bstq_pkg::*;

   logic [STATUS_W-1:0]   status;
   logic [OCC_W-1:0]      occupancy;
   logic [TICKET_W-1:0]   ticket;
   logic                  req_beat;
   logic                  rsp_stall;
   logic [RSP_DATA_W+1:0] rsp_beat;
   logic                  plain_beat;
   logic                  entry_beat;
   logic                  occ_in_range;

   assign status       = rsp_tdata[STATUS_W-1:0];
   assign occupancy    = rsp_tdata[RSP_OCC_LSB +: OCC_W];
   assign ticket       = rsp_tdata[RSP_TICKET_LSB +: TICKET_W];
   assign req_beat     = req_tvalid && req_tready && (req_tdata[0] || !req_tdata[0]);
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_beat     = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign plain_beat   = rsp_tvalid && !rsp_tuser;
   assign entry_beat   = rsp_tvalid && rsp_tuser;
   assign occ_in_range = (DEPTH > 31) || (occupancy != '0 && occupancy <= OCC_W'(DEPTH));

   // A stalled response beat stays put.
   `BSTQ_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_beat), "stalled beat changed")

   // Only one request is taken before its work starts.
   `BSTQ_ASSERT(a_one_in_flight, req_beat |=> !req_tready, "second request taken too early")

   // A beat without an entry is the single closing beat with a zero ticket.
   `BSTQ_ASSERT(a_plain_beat, plain_beat |-> rsp_tlast && ticket == '0, "bad plain beat")

   // Report beats carry ok status and a nonzero occupancy.
   `BSTQ_ASSERT(a_entry_beat, entry_beat |-> status == ST_OK && occ_in_range, "bad report beat")

endmodule

bind bulk_ticket_shift_queue bstq_checker #(
   .DEPTH (DEPTH)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### test/tb_bulk_ticket_shift_queue.sv
// ----------------------------------------------------------------------------
// Testbench for the bulk ticket shift queue
// A table of directed requests is followed by random enqueue, dequeue and
// report traffic. Each accepted request runs through a predictor of the
// queue, and every response beat is checked field by field against the
// oldest predicted beat. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------

module tb_bulk_ticket_shift_queue;
   import bstq_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 448;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 30;
   localparam int REPORT_LIMIT  = 10;

   // One response beat as the checker sees it.
   typedef struct packed {
      status_type              status;
      logic [OCC_W-1:0]        occupancy;
      logic [TICKET_W-1:0]     ticket;
      logic                    entry_valid;
      logic                    last;
   } queue_beat_type;

   // One row of the directed table; typed rows carry their expected beat.
   typedef struct packed {
      opcode_type              op;
      logic [COUNT_W-1:0]      count;
      logic                    typed;
      status_type              status;
      logic [OCC_W-1:0]        occupancy;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;

   // Queue model state.
   logic [TICKET_W-1:0]     model_tickets [QUEUE_DEPTH];
   int unsigned             model_fill = 0;
   logic [TICKET_W-1:0]     model_counter = '0;

   queue_beat_type          step_beats [$];
   queue_beat_type          awaited_beats [$];
   int unsigned             mismatch_count = 0;
   int unsigned             idle_cycles = 0;
   int unsigned             burst_left = 1;
   int unsigned             stall_tick = 0;
   int unsigned             stall_mode = 0;

   // Edge cases first: empty queue, zero counts, overflow, underflow, full drain.
   stim_row_type directed_rows [0:22] = '{
      '{OP_REPORT, 8'd0,   1'b1, ST_OK,    5'd0},
      '{OP_DEQ,    8'd0,   1'b1, ST_OK,    5'd0},
      '{OP_DEQ,    8'd1,   1'b1, ST_UNDER, 5'd0},
      '{OP_ENQ,    8'd0,   1'b1, ST_OK,    5'd0},
      '{OP_NONE,   8'd255, 1'b1, ST_OK,    5'd0},
      '{OP_ENQ,    8'd1,   1'b1, ST_OK,    5'd1},
      '{OP_REPORT, 8'd0,   1'b0, ST_OK,    5'd0},
      '{OP_ENQ,    8'd255, 1'b1, ST_OVER,  5'd16},
      '{OP_REPORT, 8'd255, 1'b0, ST_OK,    5'd0},
      '{OP_ENQ,    8'd1,   1'b1, ST_OVER,  5'd16},
      '{OP_DEQ,    8'd17,  1'b1, ST_UNDER, 5'd16},
      '{OP_DEQ,    8'd5,   1'b1, ST_OK,    5'd11},
      '{OP_REPORT, 8'd0,   1'b0, ST_OK,    5'd0},
      '{OP_DEQ,    8'd11,  1'b1, ST_OK,    5'd0},
      '{OP_REPORT, 8'd0,   1'b1, ST_OK,    5'd0},
      '{OP_ENQ,    8'd16,  1'b1, ST_OK,    5'd16},
      '{OP_DEQ,    8'd16,  1'b1, ST_OK,    5'd0},
      '{OP_ENQ,    8'd170, 1'b1, ST_OVER,  5'd16},
      '{OP_DEQ,    8'd255, 1'b1, ST_UNDER, 5'd16},
      '{OP_NONE,   8'd85,  1'b1, ST_OK,    5'd16},
      '{OP_DEQ,    8'd8,   1'b1, ST_OK,    5'd8},
      '{OP_ENQ,    8'd3,   1'b1, ST_OK,    5'd11},
      '{OP_REPORT, 8'd0,   1'b0, ST_OK,    5'd0}
   };

   bulk_ticket_shift_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Apply one request to the queue model and collect the beats it causes.
   task automatic advance_queue_model(input opcode_type op, input logic [COUNT_W-1:0] count);
      int unsigned space;
      int unsigned take;
      queue_beat_type beat;
      step_beats.delete();
      beat = '{ST_OK, '0, '0, 1'b0, 1'b1};
      case (op)
         OP_ENQ: begin
            space = QUEUE_DEPTH - model_fill;
            take = (count < space) ? count : space;
            for (int i = 0; i < take; i++) begin
               model_tickets[model_fill + i] = model_counter + i + 1;
            end
            model_fill += take;
            model_counter += count;
            beat.status = (count > space) ? ST_OVER : ST_OK;
            beat.occupancy = OCC_W'(model_fill);
            step_beats.push_back(beat);
         end
         OP_DEQ: begin
            if (count > model_fill) begin
               beat.status = ST_UNDER;
            end else begin
               for (int i = 0; i < model_fill - count; i++) begin
                  model_tickets[i] = model_tickets[i + count];
               end
               model_fill -= count;
            end
            beat.occupancy = OCC_W'(model_fill);
            step_beats.push_back(beat);
         end
         OP_REPORT: begin
            beat.occupancy = OCC_W'(model_fill);
            if (model_fill == 0) begin
               step_beats.push_back(beat);
            end else begin
               // One beat per held entry, head first; last marks the tail.
               for (int i = 0; i < model_fill; i++) begin
                  beat.ticket = model_tickets[i];
                  beat.entry_valid = 1'b1;
                  beat.last = (i == model_fill - 1);
                  step_beats.push_back(beat);
               end
            end
         end
         default: begin
            beat.occupancy = OCC_W'(model_fill);
            step_beats.push_back(beat);
         end
      endcase
   endtask

   // Present one request beat and hold it until the block takes it.
   task automatic send_request(input opcode_type op, input logic [COUNT_W-1:0] count,
                               input logic typed, input queue_beat_type typed_beat);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[OPCODE_W-1:0] = op;
      word[REQ_COUNT_LSB +: COUNT_W] = count;
      req_tdata <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_queue_model(op, count);
      if (typed) begin
         awaited_beats.push_back(typed_beat);
      end else begin
         foreach (step_beats[i]) awaited_beats.push_back(step_beats[i]);
      end
      @(negedge clock);
   endtask

   // Sender pacing: bursts with random gaps, optionally waiting for a full drain.
   task automatic pace_sender(input logic drain);
      burst_left--;
      if (drain || burst_left == 0) begin
         req_tvalid <= 1'b0;
         if (drain) begin
            do @(negedge clock); while (awaited_beats.size() != 0);
         end
         if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   // Report a failed check; only the first few are printed.
   task automatic note_mismatch(input string what, input queue_beat_type want,
                                input queue_beat_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s: expected st=%0d occ=%0d tk=%h ev=%b last=%b",
                  what, want.status, want.occupancy, want.ticket, want.entry_valid, want.last);
         $display("   got st=%0d occ=%0d tk=%h ev=%b last=%b",
                  got.status, got.occupancy, got.ticket, got.entry_valid, got.last);
      end
   endtask

   // Receiver stall pattern: phases of always ready, a fixed pattern, or random.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 256 == 255) begin
         stall_mode <= $urandom_range(0, 2);
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= !((stall_tick % 7 == 3) || (stall_tick % 13 >= 10));
         default: rsp_tready <= ($urandom_range(0, 9) >= 3);
      endcase
   end

   // Check every accepted response beat against the oldest prediction.
   always @(posedge clock) begin
      queue_beat_type got;
      queue_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[STATUS_W-1:0]);
         got.occupancy = rsp_tdata[RSP_OCC_LSB +: OCC_W];
         got.ticket = rsp_tdata[RSP_TICKET_LSB +: TICKET_W];
         got.entry_valid = rsp_tuser;
         got.last = rsp_tlast;
         if (awaited_beats.size() == 0) begin
            note_mismatch("unexpected beat", '0, got);
         end else begin
            want = awaited_beats.pop_front();
            if (got.status !== want.status || got.occupancy !== want.occupancy ||
                got.ticket !== want.ticket || got.entry_valid !== want.entry_valid ||
                got.last !== want.last) begin
               note_mismatch("beat mismatch", want, got);
            end
         end
      end
   end

   // Watchdog on cycles in which neither side moves a beat.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_bulk_ticket_shift_queue: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned done_items;
      int unsigned pick;
      logic        paused;
      opcode_type  op;
      logic [COUNT_W-1:0] cnt;
      queue_beat_type typed_beat;
      done_items = 0;
      paused = 1'b0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table; drain fully once it is done.
      foreach (directed_rows[i]) begin
         typed_beat = '{directed_rows[i].status, directed_rows[i].occupancy, '0, 1'b0, 1'b1};
         send_request(directed_rows[i].op, directed_rows[i].count, directed_rows[i].typed,
                      typed_beat);
         pace_sender(i == $size(directed_rows) - 1);
      end

      // Random traffic, weighted toward dequeues that fit and small batches.
      while (done_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         cnt = COUNT_W'($urandom_range(0, 255));
         if (pick < 40) begin
            op = OP_ENQ;
            pick = $urandom_range(0, 99);
            if (pick < 85) cnt = COUNT_W'($urandom_range(0, 6));
            else if (pick < 95) cnt = COUNT_W'($urandom_range(0, 20));
         end else if (pick < 75) begin
            op = OP_DEQ;
            if ($urandom_range(0, 99) < 85) cnt = COUNT_W'($urandom_range(0, model_fill));
            else if (model_fill < 255) cnt = COUNT_W'($urandom_range(model_fill + 1, 255));
         end else if (pick < 95) begin
            op = OP_REPORT;
         end else begin
            op = OP_NONE;
         end
         send_request(op, cnt, 1'b0, '0);
         done_items++;
         pace_sender(!paused && done_items == RANDOM_ITEMS / 2);
         if (done_items == RANDOM_ITEMS / 2) paused = 1'b1;
      end

      // Wait for every predicted beat, then watch for stray ones.
      req_tvalid <= 1'b0;
      do @(negedge clock); while (awaited_beats.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && awaited_beats.size() == 0) begin
         $display("tb_bulk_ticket_shift_queue: clean");
      end else begin
         $display("tb_bulk_ticket_shift_queue: errors");
      end
      $finish;
   end

endmodule
